// ----- hw/rtl/ngfc_pkg.sv -----
// shared constants for the n-gram frequency counter
`default_nettype none
package ngfc_pkg;
	localparam int CODE_BITS         = 5;
	localparam int SINGLE_AW         = CODE_BITS;
	localparam int PAIR_AW           = 2 * CODE_BITS;
	localparam int TRIPLE_AW         = 3 * CODE_BITS;
	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int OUT_WIDTH         = 16;

	localparam logic [1:0] REQ_TEXT  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ORDER_SINGLE = 2'd1;
	localparam logic [1:0] ORDER_PAIR   = 2'd2;
	localparam logic [1:0] ORDER_TRIPLE = 2'd3;
endpackage
`default_nettype wire

// ----- hw/rtl/ngfc_ram.sv -----
// single-port-write, single-port-read count memory with registered read data
`default_nettype none
module ngfc_ram #(
	parameter int ADDR_BITS = ngfc_pkg::SINGLE_AW,
	parameter int DATA_BITS = ngfc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [DATA_BITS-1:0] wdata,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [DATA_BITS-1:0] rdata
);
	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
	logic [DATA_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ngram_frequency_counter.sv -----
// top level of the letter n-gram frequency counter
`default_nettype none
// Requests are taken when start is high and busy is low. For a text byte,
// the three count memories are read in the accept cycle and the saturated
// counts (pair and triple only once enough letters precede) are written back
// in the next, with busy high, so a following byte always sees the updated
// counts. For a read, done and count_value appear for exactly one cycle, in
// the cycle after accept, and the receiver cannot stall them. A clear, and
// also every reset, runs a pass that zeroes one address of each memory per
// cycle while busy is high. Request type 3 is dropped with no effect.
module ngram_frequency_counter #(
	parameter int COUNT_WIDTH = ngfc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          req_type,
	input  wire logic [7:0]                          text_byte,
	input  wire logic [1:0]                          read_order,
	input  wire logic [ngfc_pkg::CODE_BITS-1:0]      first_code,
	input  wire logic [ngfc_pkg::CODE_BITS-1:0]      second_code,
	input  wire logic [ngfc_pkg::CODE_BITS-1:0]      third_code,
	output logic                                     done,
	output logic [ngfc_pkg::OUT_WIDTH-1:0]           count_value
);
	localparam int CB  = ngfc_pkg::CODE_BITS;
	localparam int SAW = ngfc_pkg::SINGLE_AW;
	localparam int PAW = ngfc_pkg::PAIR_AW;
	localparam int TAW = ngfc_pkg::TRIPLE_AW;
	localparam int OW  = ngfc_pkg::OUT_WIDTH;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	logic [TAW-1:0] clr_q;
	logic [CB-1:0]  last_q;
	logic [CB-1:0]  before_q;
	logic [1:0]     hist_q;
	logic           done_q;
	logic [1:0]     order_s1;
	logic           pair_en_s1;
	logic           triple_en_s1;
	logic [SAW-1:0] s_addr_s1;
	logic [PAW-1:0] p_addr_s1;
	logic [TAW-1:0] t_addr_s1;

	logic           accept;
	logic           clearing;
	logic           updating;
	logic [7:0]     byte_m1;
	logic [CB-1:0]  code;
	logic           is_text;
	logic [SAW-1:0] s_raddr;
	logic [PAW-1:0] p_raddr;
	logic [TAW-1:0] t_raddr;
	logic [COUNT_WIDTH-1:0] s_rdata, p_rdata, t_rdata;
	logic [COUNT_WIDTH-1:0] s_wdata, p_wdata, t_wdata;
	logic [SAW-1:0] s_waddr;
	logic [PAW-1:0] p_waddr;
	logic [TAW-1:0] t_waddr;
	logic           s_we, p_we, t_we;
	logic [COUNT_WIDTH-1:0] sel_count;
	logic [COUNT_WIDTH+OW-1:0] sel_ext;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign clearing = (state_q == ST_CLEAR);
	assign updating = (state_q == ST_UPDATE);
	assign byte_m1  = text_byte - 8'd1;
	assign code     = byte_m1[CB-1:0];
	assign is_text  = (req_type == ngfc_pkg::REQ_TEXT);

	assign s_raddr = is_text ? code : first_code;
	assign p_raddr = is_text ? {last_q, code} : {first_code, second_code};
	assign t_raddr = is_text ? {before_q, last_q, code}
	                         : {first_code, second_code, third_code};

	assign s_waddr = clearing ? clr_q[SAW-1:0] : s_addr_s1;
	assign p_waddr = clearing ? clr_q[PAW-1:0] : p_addr_s1;
	assign t_waddr = clearing ? clr_q : t_addr_s1;

	// saturating increment of the counts read in the accept cycle, or zero during a clear
	assign s_wdata = clearing ? '0 : ((&s_rdata) ? s_rdata : s_rdata + 1'b1);
	assign p_wdata = clearing ? '0 : ((&p_rdata) ? p_rdata : p_rdata + 1'b1);
	assign t_wdata = clearing ? '0 : ((&t_rdata) ? t_rdata : t_rdata + 1'b1);

	assign s_we = clearing || updating;
	assign p_we = clearing || (updating && pair_en_s1);
	assign t_we = clearing || (updating && triple_en_s1);

	ngfc_ram #(.ADDR_BITS(SAW), .DATA_BITS(COUNT_WIDTH)) u_single (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	ngfc_ram #(.ADDR_BITS(PAW), .DATA_BITS(COUNT_WIDTH)) u_pair (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	ngfc_ram #(.ADDR_BITS(TAW), .DATA_BITS(COUNT_WIDTH)) u_triple (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			last_q   <= '0;
			before_q <= '0;
			hist_q   <= 2'd0;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept && (req_type == ngfc_pkg::REQ_READ);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_text) begin
						state_q  <= ST_UPDATE;
						before_q <= last_q;
						last_q   <= code;
						if (hist_q != 2'd2) begin
							hist_q <= hist_q + 2'd1;
						end
					end else if (accept && (req_type == ngfc_pkg::REQ_CLEAR)) begin
						state_q  <= ST_CLEAR;
						clr_q    <= '0;
						last_q   <= '0;
						before_q <= '0;
						hist_q   <= 2'd0;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// payload of the word in flight, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			order_s1     <= read_order;
			pair_en_s1   <= (hist_q != 2'd0);
			triple_en_s1 <= (hist_q == 2'd2);
			s_addr_s1    <= s_raddr;
			p_addr_s1    <= p_raddr;
			t_addr_s1    <= t_raddr;
		end
	end

	always_comb begin
		case (order_s1)
			ngfc_pkg::ORDER_SINGLE: sel_count = s_rdata;
			ngfc_pkg::ORDER_PAIR:   sel_count = p_rdata;
			ngfc_pkg::ORDER_TRIPLE: sel_count = t_rdata;
			default:                sel_count = '0;
		endcase
	end

	assign sel_ext     = {{OW{1'b0}}, sel_count};
	assign count_value = sel_ext[OW-1:0];
	assign done        = done_q;

	a_read_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == ngfc_pkg::REQ_READ) |=> done)
		else $error("read accepted but no word delivered");

	a_word_only_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && (req_type == ngfc_pkg::REQ_READ)))
		else $error("word delivered without a read");

	a_text_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_text |=> busy && !done)
		else $error("text byte write-back not interlocked");

	a_clear_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == ngfc_pkg::REQ_CLEAR) |=> clearing && (clr_q == '0))
		else $error("clear did not start a clearing pass");
endmodule
`default_nettype wire

// ----- tb/ngram_frequency_counter_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the letter n-gram frequency counter
module ngram_frequency_counter_tb;
	localparam int CB  = ngfc_pkg::CODE_BITS;
	localparam int SAW = ngfc_pkg::SINGLE_AW;
	localparam int PAW = ngfc_pkg::PAIR_AW;
	localparam int TAW = ngfc_pkg::TRIPLE_AW;
	localparam int OW  = ngfc_pkg::OUT_WIDTH;

	localparam logic [1:0] REQ_NONE   = 2'd3;
	localparam logic [1:0] ORDER_NONE = 2'd0;
	localparam int unsigned COUNT_MAX = (1 << ngfc_pkg::COUNT_WIDTH_DEF) - 1;
	localparam int SAT_RUN            = 40;
	localparam int HIST_KEEP          = 48;

	typedef struct packed {
		logic [1:0]    req_type;
		logic [7:0]    text_byte;
		logic [1:0]    read_order;
		logic [CB-1:0] first_code;
		logic [CB-1:0] second_code;
		logic [CB-1:0] third_code;
	} req_word_t;

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          start       = 1'b0;
	logic [1:0]    req_type    = '0;
	logic [7:0]    text_byte   = '0;
	logic [1:0]    read_order  = '0;
	logic [CB-1:0] first_code  = '0;
	logic [CB-1:0] second_code = '0;
	logic [CB-1:0] third_code  = '0;
	logic          busy;
	logic          done;
	logic [OW-1:0] count_value;

	ngram_frequency_counter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.text_byte   (text_byte),
		.read_order  (read_order),
		.first_code  (first_code),
		.second_code (second_code),
		.third_code  (third_code),
		.done        (done),
		.count_value (count_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// expected n-gram tables and letter history
	int unsigned   single_tab [1 << SAW];
	int unsigned   pair_tab [1 << PAW];
	int unsigned   triple_tab [1 << TAW];
	logic [CB-1:0] last_c;
	logic [CB-1:0] prev_c;
	int            hist_len;
	logic [OW-1:0] count_queue [$];

	req_word_t     word_queue [$];
	logic [CB-1:0] recent_codes [$];
	req_word_t     cur_word;
	int            burst_left;
	int            gap_left;
	int            error_count = 0;

	task automatic report_mismatch(input string what);
		if (error_count < 30)
			$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic void wipe_tables();
		foreach (single_tab[i]) single_tab[i] = 0;
		foreach (pair_tab[i]) pair_tab[i] = 0;
		foreach (triple_tab[i]) triple_tab[i] = 0;
		last_c = '0;
		prev_c = '0;
		hist_len = 0;
	endfunction

	function automatic void tally_word(input req_word_t w);
		logic [7:0]    shifted;
		logic [CB-1:0] code;
		int unsigned   hit;
		case (w.req_type)
			ngfc_pkg::REQ_TEXT: begin
				shifted = w.text_byte - 8'd1;
				code = shifted[CB-1:0];
				if (single_tab[code] < COUNT_MAX)
					single_tab[code]++;
				if (hist_len >= 1 && pair_tab[{last_c, code}] < COUNT_MAX)
					pair_tab[{last_c, code}]++;
				if (hist_len >= 2 && triple_tab[{prev_c, last_c, code}] < COUNT_MAX)
					triple_tab[{prev_c, last_c, code}]++;
				prev_c = last_c;
				last_c = code;
				if (hist_len < 2)
					hist_len++;
			end
			ngfc_pkg::REQ_READ: begin
				case (w.read_order)
					ngfc_pkg::ORDER_SINGLE: hit = single_tab[w.first_code];
					ngfc_pkg::ORDER_PAIR:   hit = pair_tab[{w.first_code, w.second_code}];
					ngfc_pkg::ORDER_TRIPLE:
						hit = triple_tab[{w.first_code, w.second_code, w.third_code}];
					default:                hit = 0;
				endcase
				count_queue.push_back(hit[OW-1:0]);
			end
			ngfc_pkg::REQ_CLEAR: wipe_tables();
			default: ;
		endcase
	endfunction

	function automatic logic [CB-1:0] rnd_code();
		return CB'($urandom);
	endfunction

	function automatic req_word_t noise_word();
		logic [31:0] r;
		req_word_t   w;
		r = $urandom;
		w = r[$bits(req_word_t)-1:0];
		return w;
	endfunction

	function automatic logic [7:0] pick_byte(input int mode);
		case (mode)
			0: return 8'h61 + 8'($urandom_range(3));
			1: return 8'h61 + 8'($urandom_range(25));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_text(input logic [7:0] b);
		req_word_t  w;
		logic [7:0] shifted;
		w = noise_word();
		w.req_type = ngfc_pkg::REQ_TEXT;
		w.text_byte = b;
		word_queue.push_back(w);
		shifted = b - 8'd1;
		recent_codes.push_back(shifted[CB-1:0]);
		if (recent_codes.size() > HIST_KEEP)
			void'(recent_codes.pop_front());
	endtask

	task automatic push_read(input logic [1:0] ord, input logic [CB-1:0] a,
			input logic [CB-1:0] b, input logic [CB-1:0] c);
		req_word_t w;
		w = noise_word();
		w.req_type = ngfc_pkg::REQ_READ;
		w.read_order = ord;
		w.first_code = a;
		w.second_code = b;
		w.third_code = c;
		word_queue.push_back(w);
	endtask

	task automatic push_clear();
		req_word_t w;
		w = noise_word();
		w.req_type = ngfc_pkg::REQ_CLEAR;
		word_queue.push_back(w);
		recent_codes.delete();
	endtask

	task automatic push_dropped();
		req_word_t w;
		w = noise_word();
		w.req_type = REQ_NONE;
		word_queue.push_back(w);
	endtask

	// read an n-gram that really occurred in the recent text, or a random one while the history is too short
	task automatic push_history_read();
		logic [1:0] ord;
		int         n;
		int         p;
		ord = 2'($urandom_range(3, 1));
		n = int'(ord);
		if (recent_codes.size() < n) begin
			push_read(ord, rnd_code(), rnd_code(), rnd_code());
		end else begin
			p = $urandom_range(recent_codes.size() - n);
			push_read(ord, recent_codes[p],
				(n > 1) ? recent_codes[p + 1] : rnd_code(),
				(n > 2) ? recent_codes[p + 2] : rnd_code());
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			wipe_tables();
		end else begin
			if (start && !busy)
				tally_word(cur_word);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (word_queue.size() > 0) begin
					cur_word = word_queue.pop_front();
					start <= 1'b1;
					req_type <= cur_word.req_type;
					text_byte <= cur_word.text_byte;
					read_order <= cur_word.read_order;
					first_code <= cur_word.first_code;
					second_code <= cur_word.second_code;
					third_code <= cur_word.third_code;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(24, 1);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		logic [OW-1:0] want;
		if (arst_n && done) begin
			if (count_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected count %0d", count_value));
			end else begin
				want = count_queue.pop_front();
				if (count_value !== want)
					report_mismatch($sformatf("count %0d, expected %0d", count_value, want));
			end
		end
	end

	initial begin
		int pick;

		// directed: byte extremes, every request kind, history after clear
		push_read(ngfc_pkg::ORDER_SINGLE, 5'd0, rnd_code(), rnd_code());
		push_read(ngfc_pkg::ORDER_TRIPLE, 5'd31, 5'd31, 5'd31);
		push_text(8'h00);
		push_text(8'h01);
		push_text(8'hff);
		push_text(8'h20);
		push_text(8'h41);
		push_text(8'h80);
		push_text(8'h00);
		push_text(8'h01);
		push_read(ngfc_pkg::ORDER_SINGLE, 5'd31, rnd_code(), rnd_code());
		push_read(ngfc_pkg::ORDER_PAIR, 5'd31, 5'd0, rnd_code());
		push_read(ngfc_pkg::ORDER_TRIPLE, 5'd31, 5'd0, 5'd30);
		push_read(ngfc_pkg::ORDER_TRIPLE, 5'd31, 5'd31, 5'd0);
		push_read(ORDER_NONE, 5'd31, 5'd0, 5'd30);
		push_dropped();
		push_read(ngfc_pkg::ORDER_SINGLE, 5'd31, rnd_code(), rnd_code());
		push_clear();
		push_read(ngfc_pkg::ORDER_SINGLE, 5'd31, rnd_code(), rnd_code());
		push_text(8'h61);
		push_text(8'h62);
		push_read(ngfc_pkg::ORDER_PAIR, 5'd0, 5'd1, rnd_code());
		push_read(ngfc_pkg::ORDER_PAIR, 5'd0, 5'd0, rnd_code());
		push_read(ngfc_pkg::ORDER_TRIPLE, 5'd0, 5'd0, 5'd1);
		push_text(8'h63);
		push_read(ngfc_pkg::ORDER_TRIPLE, 5'd0, 5'd1, 5'd2);

		// one repeated letter hitting the same entries of all three tables
		push_clear();
		for (int i = 1; i <= SAT_RUN; i++) begin
			push_text(8'h00);
			if (i >= SAT_RUN - 6) begin
				push_read(ngfc_pkg::ORDER_SINGLE, 5'd31, rnd_code(), rnd_code());
				push_read(ngfc_pkg::ORDER_PAIR, 5'd31, 5'd31, rnd_code());
				push_read(ngfc_pkg::ORDER_TRIPLE, 5'd31, 5'd31, 5'd31);
			end
		end
		push_clear();

		// random text with reads aimed mostly at n-grams that occurred
		for (int seg = 0; seg < 3; seg++) begin
			for (int i = 0; i < 320; i++) begin
				pick = $urandom_range(99);
				if (pick < 55)
					push_text(pick_byte(seg));
				else if (pick < 85)
					push_history_read();
				else if (pick < 95)
					push_read(2'($urandom), rnd_code(), rnd_code(), rnd_code());
				else if (pick < 98)
					push_read(ORDER_NONE, rnd_code(), rnd_code(), rnd_code());
				else
					push_dropped();
			end
			if (seg < 2)
				push_clear();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || start || count_queue.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/ngfc_pkg.sv
hw/rtl/ngfc_ram.sv
hw/rtl/ngram_frequency_counter.sv
tb/ngram_frequency_counter_tb.sv
